@@ hdl/grs_pkg.sv @@
// grs_pkg: shared types, codes and constants of the gradient ramp sampler
// used by grs_ctrl, grs_datapath and gradient_ramp_sampler
// no dependencies
package grs_pkg;

    // item kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_APPEND = 2'd1;
    localparam kind_t KIND_SAMPLE = 2'd2;
    localparam kind_t KIND_UNUSED = 2'd3;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // configuration register indexes
    typedef logic cfg_index_t;
    localparam cfg_index_t CFG_GRADIENT_TYPE = 1'b0;
    localparam cfg_index_t CFG_FOCAL_Q8      = 1'b1;

    // result colour source
    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EMIT_ZERO  = 3'd0;
    localparam emit_sel_t EMIT_FIRST = 3'd1;
    localparam emit_sel_t EMIT_LAST  = 3'd2;
    localparam emit_sel_t EMIT_PAIR  = 3'd3;
    localparam emit_sel_t EMIT_QUOT  = 3'd4;

    // shared multiplier operand selection
    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_NONE = 3'd0;
    localparam mul_op_t MUL_DD   = 3'd1;
    localparam mul_op_t MUL_XX   = 3'd2;
    localparam mul_op_t MUL_YY   = 3'd3;
    localparam mul_op_t MUL_YD   = 3'd4;
    localparam mul_op_t MUL_RHS  = 3'd5;
    localparam mul_op_t MUL_SQ   = 3'd6;
    localparam mul_op_t MUL_TD   = 3'd7;

    // 511 * 511, scale of the radial distance test
    localparam int unsigned RAD_K = 261121;

    // one gradient stop: ratio and colour (red, green, blue, alpha from the top)
    typedef struct packed {
        logic [7:0]      ratio;
        logic [3:0][7:0] col;
    } stop_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      clear_count;
        logic      append;
        logic      ratio_lin;
        logic      radial_init;
        mul_op_t   mul_op;
        logic      cap_dd;
        logic      cap_xx;
        logic      cap_s;
        logic      cap_rhs;
        logic      cmp_step;
        logic      scan_init;
        logic      scan_step;
        logic      mac_clr;
        logic      mac_step;
        logic      div_step;
        logic      step_inc;
        logic      emit;
        emit_sel_t emit_sel;
        status_t   emit_status;
    } grs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        kind_t kind;
        logic  radial;
        logic  empty;
        logic  full;
        logic  scan_done;
        logic  clamp_lo;
        logic  clamp_hi;
        logic  pair_eq;
        logic  step_last;
    } grs_stat_t;

endpackage

@@ hdl/grs_ram.sv @@
// grs_ram: generic single write port, single read port ram with registered read
// no dependencies
module grs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/grs_ctrl.sv @@
// grs_ctrl: sequencing state machine of the gradient ramp sampler
// depends on grs_pkg
module grs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output grs_pkg::grs_cmd_t cmd,
    input  grs_pkg::grs_stat_t stat
);
    import grs_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DECODE = 5'd1;
    localparam logic [4:0] ST_R_DD   = 5'd2;
    localparam logic [4:0] ST_R_XX   = 5'd3;
    localparam logic [4:0] ST_R_YY   = 5'd4;
    localparam logic [4:0] ST_R_YD   = 5'd5;
    localparam logic [4:0] ST_R_S    = 5'd6;
    localparam logic [4:0] ST_R_RHS  = 5'd7;
    localparam logic [4:0] ST_R_CAPR = 5'd8;
    localparam logic [4:0] ST_IT_SQ  = 5'd9;
    localparam logic [4:0] ST_IT_TD  = 5'd10;
    localparam logic [4:0] ST_IT_CMP = 5'd11;
    localparam logic [4:0] ST_SCAN   = 5'd12;
    localparam logic [4:0] ST_DECIDE = 5'd13;
    localparam logic [4:0] ST_MAC    = 5'd14;
    localparam logic [4:0] ST_DIV    = 5'd15;
    localparam logic [4:0] ST_FIN    = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       done_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = 1'b1;
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.kind)
                    KIND_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.emit        = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    KIND_APPEND:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.full)
                        begin
                            cmd.emit_status = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    KIND_SAMPLE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = STATUS_EMPTY;
                            state_next      = ST_IDLE;
                        end
                        else if (stat.radial)
                        begin
                            cmd.radial_init = 1'b1;
                            state_next      = ST_R_DD;
                        end
                        else
                        begin
                            cmd.ratio_lin = 1'b1;
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            // radial: squares and products through the shared multiplier
            ST_R_DD:
            begin
                cmd.mul_op = MUL_DD;
                state_next = ST_R_XX;
            end
            ST_R_XX:
            begin
                cmd.cap_dd = 1'b1;
                cmd.mul_op = MUL_XX;
                state_next = ST_R_YY;
            end
            ST_R_YY:
            begin
                cmd.cap_xx = 1'b1;
                cmd.mul_op = MUL_YY;
                state_next = ST_R_YD;
            end
            ST_R_YD:
            begin
                cmd.mul_op = MUL_YD;
                state_next = ST_R_S;
            end
            ST_R_S:
            begin
                cmd.cap_s  = 1'b1;
                state_next = ST_R_RHS;
            end
            ST_R_RHS:
            begin
                cmd.mul_op = MUL_RHS;
                state_next = ST_R_CAPR;
            end
            ST_R_CAPR:
            begin
                cmd.cap_rhs = 1'b1;
                state_next  = ST_IT_SQ;
            end
            // radial: one ratio bit per pass, msb first
            ST_IT_SQ:
            begin
                cmd.mul_op = MUL_SQ;
                state_next = ST_IT_TD;
            end
            ST_IT_TD:
            begin
                cmd.mul_op = MUL_TD;
                state_next = ST_IT_CMP;
            end
            ST_IT_CMP:
            begin
                cmd.cmp_step = 1'b1;
                cmd.step_inc = 1'b1;
                if (stat.step_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IT_SQ;
                end
            end
            // walk the stop table
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.mac_clr = 1'b1;
                if (stat.clamp_lo)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_FIRST;
                    state_next   = ST_IDLE;
                end
                else if (stat.clamp_hi)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_LAST;
                    state_next   = ST_IDLE;
                end
                else if (stat.pair_eq)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_PAIR;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                cmd.step_inc = 1'b1;
                if (stat.step_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.step_inc = 1'b1;
                if (stat.step_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_QUOT;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

@@ hdl/grs_datapath.sv @@
// grs_datapath: stop table, radial ratio unit, stop search and per-channel blend
// depends on grs_pkg and grs_ram
module grs_datapath #(
    parameter int MAX_STOPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  grs_pkg::grs_cmd_t     cmd,
    output grs_pkg::grs_stat_t    stat,
    input  logic [1:0]            kind,
    input  logic [7:0]            stop_ratio,
    input  logic [7:0]            stop_red,
    input  logic [7:0]            stop_green,
    input  logic [7:0]            stop_blue,
    input  logic [7:0]            stop_alpha,
    input  logic [7:0]            pos_x,
    input  logic [5:0]            pos_y,
    input  logic                  cfg_we,
    input  grs_pkg::cfg_index_t   cfg_index,
    input  logic [9:0]            cfg_data,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic [7:0]            out_alpha,
    output logic [1:0]            status
);
    import grs_pkg::*;

    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int IDX_W = $clog2(MAX_STOPS);

    // configuration
    logic       gradient_type_reg;
    logic [9:0] focal_reg;

    // captured item
    kind_t      kind_reg;
    stop_t      new_stop_reg;
    logic [7:0] pos_x_reg;
    logic [5:0] pos_y_reg;

    // table control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             pend_reg;
    logic [CNT_W-1:0] pend_idx_reg;
    logic             issue;
    stop_t            rd_stop;
    logic [39:0]      rd_data;

    // radial unit
    logic [9:0]  abs_a;
    logic [9:0]  dsum;
    logic [9:0]  col8;
    logic [9:0]  ax;
    logic [5:0]  ay;
    logic [7:0]  bit_mask;
    logic [7:0]  trial;
    logic [19:0] mul_a;
    logic [30:0] mul_b;
    logic [50:0] mul_reg;
    logic [19:0] dd_reg;
    logic [19:0] xx_reg;
    logic [30:0] s_reg;
    logic [48:0] rhs_reg;
    logic [47:0] lhs;
    logic [2:0]  step_reg;

    // search and blend
    logic [7:0]       ratio_reg;
    stop_t            first_reg;
    stop_t            prev_reg;
    stop_t            lo_reg;
    stop_t            hi_reg;
    logic [7:0]       w_lo;
    logic [7:0]       w_hi;
    logic [7:0]       wt;
    logic [3:0][15:0] acc_reg;
    logic [3:0][15:0] acc_next;
    logic [3:0][7:0]  out_col_reg;
    logic [3:0][7:0]  out_col_next;
    status_t          out_status_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gradient_type_reg <= 1'b0;
            focal_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRADIENT_TYPE: gradient_type_reg <= cfg_data[0];
                CFG_FOCAL_Q8:      focal_reg         <= cfg_data;
                default:           gradient_type_reg <= gradient_type_reg;
            endcase
        end
    end

    // item capture while idle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg         <= kind;
            new_stop_reg     <= {stop_ratio, stop_red, stop_green, stop_blue, stop_alpha};
            pos_x_reg        <= pos_x;
            pos_y_reg        <= pos_y;
        end
    end

    // stop table storage
    grs_ram #(
        .WIDTH (40),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (new_stop_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign rd_stop = stop_t'(rd_data);
    assign issue   = cmd.scan_step && (rd_cnt_reg < count_reg);

    // stop count and read sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            pend_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                rd_cnt_reg <= '0;
                pend_reg   <= 1'b0;
            end
            else
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
            end
            if (cmd.radial_init || cmd.mac_clr)
            begin
                step_reg <= '0;
            end
            else if (cmd.step_inc)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // stop search: first, last and last matching pair
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= rd_cnt_reg;
        end
        if (cmd.scan_step && pend_reg)
        begin
            if (pend_idx_reg == '0)
            begin
                first_reg <= rd_stop;
            end
            else if ((prev_reg.ratio <= ratio_reg) && (ratio_reg <= rd_stop.ratio))
            begin
                lo_reg <= prev_reg;
                hi_reg <= rd_stop;
            end
            prev_reg <= rd_stop;
        end
    end

    // radial geometry from the captured texel
    always_comb
    begin
        abs_a    = focal_reg[9] ? (~focal_reg + 10'd1) : focal_reg;
        dsum     = 10'd256 + abs_a;
        col8     = {1'b0, pos_x_reg[5:0], 3'b000};
        ax       = (col8 >= dsum) ? (col8 - dsum) : (dsum - col8);
        ay       = (pos_y_reg >= 6'd32) ? (pos_y_reg - 6'd32) : (6'd32 - pos_y_reg);
        bit_mask = 8'h80 >> step_reg;
        trial    = ratio_reg | bit_mask;
        lhs      = {mul_reg[35:0], 12'h000};
    end

    // shared multiplier operands; dy squared and the trial square are taken
    // straight from the product register in the cycle after they are formed
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_DD:
            begin
                mul_a = 20'(dsum);
                mul_b = 31'(dsum);
            end
            MUL_XX:
            begin
                mul_a = 20'(ax);
                mul_b = 31'(ax);
            end
            MUL_YY:
            begin
                mul_a = 20'(ay);
                mul_b = 31'(ay);
            end
            MUL_YD:
            begin
                mul_a = dd_reg;
                mul_b = 31'(mul_reg[10:0]);
            end
            MUL_RHS:
            begin
                mul_a = 20'(RAD_K);
                mul_b = s_reg;
            end
            MUL_SQ:
            begin
                mul_a = 20'(trial);
                mul_b = 31'(trial);
            end
            MUL_TD:
            begin
                mul_a = dd_reg;
                mul_b = 31'(mul_reg[15:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // multiplier product and radial registers
    always_ff @(posedge clk)
    begin
        mul_reg <= 51'(mul_a) * 51'(mul_b);
        if (cmd.cap_dd)
        begin
            dd_reg <= mul_reg[19:0];
        end
        if (cmd.cap_xx)
        begin
            xx_reg <= mul_reg[19:0];
        end
        if (cmd.cap_s)
        begin
            s_reg <= 31'({xx_reg, 10'h000}) + mul_reg[30:0];
        end
        if (cmd.cap_rhs)
        begin
            rhs_reg <= mul_reg[48:0];
        end
    end

    // sample ratio: linear position or radial bits
    always_ff @(posedge clk)
    begin
        if (cmd.ratio_lin)
        begin
            ratio_reg <= pos_x_reg;
        end
        else if (cmd.radial_init)
        begin
            ratio_reg <= '0;
        end
        else if (cmd.cmp_step && (49'(lhs) <= rhs_reg))
        begin
            ratio_reg <= trial;
        end
    end

    // blend weights of the matching pair
    assign w_lo = hi_reg.ratio - ratio_reg;
    assign w_hi = ratio_reg - lo_reg.ratio;
    assign wt   = hi_reg.ratio - lo_reg.ratio;

    // per-channel shift-add numerator, then restoring division
    always_comb
    begin
        logic [8:0]  part;
        logic [16:0] sum;
        logic [7:0]  rem;
        acc_next = acc_reg;
        for (int ch = 0; ch < 4; ch++)
        begin
            part = '0;
            sum  = '0;
            rem  = '0;
            if (cmd.mac_clr)
            begin
                acc_next[ch] = '0;
            end
            else if (cmd.mac_step)
            begin
                sum = {acc_reg[ch], 1'b0}
                    + (w_lo[~step_reg] ? 17'(lo_reg.col[ch]) : 17'd0)
                    + (w_hi[~step_reg] ? 17'(hi_reg.col[ch]) : 17'd0);
                acc_next[ch] = sum[15:0];
            end
            else if (cmd.div_step)
            begin
                part = {acc_reg[ch][15:8], acc_reg[ch][7]};
                if (part >= 9'(wt))
                begin
                    rem = 8'(part - 9'(wt));
                    acc_next[ch] = {rem, acc_reg[ch][6:0], 1'b1};
                end
                else
                begin
                    acc_next[ch] = {part[7:0], acc_reg[ch][6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // result colour selection
    always_comb
    begin
        out_col_next = '0;
        case (cmd.emit_sel)
            EMIT_FIRST: out_col_next = first_reg.col;
            EMIT_LAST:  out_col_next = prev_reg.col;
            EMIT_PAIR:  out_col_next = hi_reg.col;
            EMIT_QUOT:
            begin
                for (int ch = 0; ch < 4; ch++)
                begin
                    out_col_next[ch] = acc_reg[ch][7:0];
                end
            end
            default:    out_col_next = '0;
        endcase
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_col_reg    <= out_col_next;
            out_status_reg <= cmd.emit_status;
        end
    end

    // status to the controller
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.radial    = gradient_type_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(MAX_STOPS));
        stat.scan_done = pend_reg && ((pend_idx_reg + 1'b1) == count_reg);
        stat.clamp_lo  = (ratio_reg < first_reg.ratio);
        stat.clamp_hi  = (ratio_reg >= prev_reg.ratio);
        stat.pair_eq   = (lo_reg.ratio == hi_reg.ratio);
        stat.step_last = (step_reg == 3'd7);
    end

    assign out_red   = out_col_reg[3];
    assign out_green = out_col_reg[2];
    assign out_blue  = out_col_reg[1];
    assign out_alpha = out_col_reg[0];
    assign status    = out_status_reg;

endmodule

@@ hdl/gradient_ramp_sampler.sv @@
// gradient_ramp_sampler: top level, gradient stop table and ramp sampler
// depends on grs_pkg, grs_ctrl, grs_datapath and grs_ram
//
// Usage: an item (clear, append or sample) is taken at a clock edge where
// start is high and busy is low; busy stays high until the cycle its result
// is out. Each item gives exactly one result: out_* and status valid for the
// single cycle in which done is high. The receiver cannot stall; the result
// must be taken in that cycle. A new item may be started in the cycle done is
// high, so throughput is one item per latency.
// Clear and append are decided in the decode state. A linear sample walks the
// table with one read per stop held through the ram port, then runs one
// shift-add step per weight bit and one divide step per quotient bit for the
// per-channel blend. A radial sample first adds a distance test: a setup
// sequence on the shared multiplier, then a square, a product and a compare per ratio bit.
// Samples clamped to an end stop, or landing on equal stop ratios, skip the
// blend.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// writes only while idle, not enforced by the block; cfg_ready is always high.
// Reset (rst_n low) empties the table, clears both registers, keeps ram data.
module gradient_ramp_sampler #(
    parameter int MAX_STOPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] stop_ratio,
    input  logic [7:0] stop_red,
    input  logic [7:0] stop_green,
    input  logic [7:0] stop_blue,
    input  logic [7:0] stop_alpha,
    input  logic [7:0] pos_x,
    input  logic [5:0] pos_y,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  grs_pkg::cfg_index_t cfg_index,
    input  logic [9:0] cfg_data,
    output logic       done,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic [1:0] status
);
    import grs_pkg::*;

    grs_cmd_t  cmd;
    grs_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencing
    grs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // table, ratio and blend
    grs_datapath #(
        .MAX_STOPS (MAX_STOPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .stop_ratio (stop_ratio),
        .stop_red   (stop_red),
        .stop_green (stop_green),
        .stop_blue  (stop_blue),
        .stop_alpha (stop_alpha),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .status     (status)
    );

endmodule
